// ----- src/osmt_pkg.sv -----
package osmt_pkg;

  localparam int unsigned ENTRY_COUNT_DEF = 16;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned DESC_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned GRANT_W  = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE  = 2'd0,
    CMD_PUT     = 2'd1,
    CMD_TAKE    = 2'd2,
    CMD_DESTROY = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_NO_FREE = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_READ,
    S_DONE
  } state_t;

endpackage

// ----- src/one_slot_mailbox_table.sv -----
// Table of ENTRY_COUNT one-word mailboxes driven by create/put/take/destroy
// commands; every command returns exactly one result beat and never blocks
// (full or empty entries answer would-block). One command is handled at a
// time: in_stall stays high from acceptance until the result beat is taken.
// Create walks the in-use bits one entry per cycle from entry 0 until it finds
// a free entry or reaches the last one. Put and destroy go through the check
// state to the result; take also passes a read state, as the word memory has
// a registered read port.
module one_slot_mailbox_table #(
  parameter int unsigned ENTRY_COUNT = osmt_pkg::ENTRY_COUNT_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [osmt_pkg::CMD_W-1:0]             in_command,
  input  logic [osmt_pkg::DESC_W-1:0]            in_descriptor,
  input  logic signed [osmt_pkg::WORD_W-1:0]     in_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [osmt_pkg::STATUS_W-1:0]          out_status,
  output logic [osmt_pkg::GRANT_W-1:0]           out_granted_descriptor,
  output logic signed [osmt_pkg::WORD_W-1:0]     out_taken_value
);

  localparam int unsigned IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int unsigned CMP_W = osmt_pkg::DESC_W + 1;

  osmt_pkg::state_t state_r, state_nxt;

  logic [ENTRY_COUNT-1:0]           in_use_r;
  logic [ENTRY_COUNT-1:0]           full_r;
  logic [osmt_pkg::WORD_W-1:0]      slot_word [ENTRY_COUNT];
  logic [osmt_pkg::WORD_W-1:0]      rd_data_r;

  osmt_pkg::cmd_t                   cmd_r;
  logic [osmt_pkg::DESC_W-1:0]      desc_r;
  logic [osmt_pkg::WORD_W-1:0]      value_r;
  logic [IDX_W-1:0]                 scan_r;

  osmt_pkg::status_t                status_r;
  logic [osmt_pkg::GRANT_W-1:0]     granted_r;
  logic [osmt_pkg::WORD_W-1:0]      taken_r;

  logic                             in_acc;
  logic                             out_acc;
  logic [IDX_W-1:0]                 d_idx;
  logic                             d_live;
  logic                             scan_free;
  logic                             scan_last;
  logic [osmt_pkg::DESC_W-1:0]      scan_ext;

  // decoded actions
  logic                             do_claim;
  logic                             do_put;
  logic                             do_take;
  logic                             do_destroy;
  logic                             ld_result;
  osmt_pkg::status_t                res_status;
  logic [osmt_pkg::GRANT_W-1:0]     res_granted;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  assign d_idx     = desc_r[IDX_W-1:0];
  assign d_live    = ({1'b0, desc_r} < CMP_W'(ENTRY_COUNT)) && in_use_r[d_idx];
  assign scan_free = !in_use_r[scan_r];
  assign scan_last = (scan_r == IDX_W'(ENTRY_COUNT - 1));
  assign scan_ext  = osmt_pkg::DESC_W'(scan_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      osmt_pkg::S_IDLE: begin
        if (in_acc) begin
          if (osmt_pkg::cmd_t'(in_command) == osmt_pkg::CMD_CREATE) begin
            state_nxt = osmt_pkg::S_SCAN;
          end else begin
            state_nxt = osmt_pkg::S_CHECK;
          end
        end
      end
      osmt_pkg::S_SCAN: begin
        if (scan_free || scan_last) begin
          state_nxt = osmt_pkg::S_DONE;
        end
      end
      osmt_pkg::S_CHECK: begin
        if (do_take) begin
          state_nxt = osmt_pkg::S_READ;
        end else begin
          state_nxt = osmt_pkg::S_DONE;
        end
      end
      osmt_pkg::S_READ: state_nxt = osmt_pkg::S_DONE;
      osmt_pkg::S_DONE: begin
        if (out_acc) begin
          state_nxt = osmt_pkg::S_IDLE;
        end
      end
      default: state_nxt = osmt_pkg::S_IDLE;
    endcase
  end

  // actions and result
  always_comb begin
    do_claim    = 1'b0;
    do_put      = 1'b0;
    do_take     = 1'b0;
    do_destroy  = 1'b0;
    ld_result   = 1'b0;
    res_status  = osmt_pkg::ST_OK;
    res_granted = '0;
    unique case (state_r)
      osmt_pkg::S_SCAN: begin
        if (scan_free) begin
          do_claim    = 1'b1;
          ld_result   = 1'b1;
          res_granted = scan_ext[osmt_pkg::GRANT_W-1:0];
        end else if (scan_last) begin
          ld_result  = 1'b1;
          res_status = osmt_pkg::ST_NO_FREE;
        end
      end
      osmt_pkg::S_CHECK: begin
        ld_result = 1'b1;
        if (!d_live) begin
          res_status = osmt_pkg::ST_INVALID;
        end else begin
          case (cmd_r)
            osmt_pkg::CMD_PUT: begin
              if (full_r[d_idx]) begin
                res_status = osmt_pkg::ST_FULL;
              end else begin
                do_put = 1'b1;
              end
            end
            osmt_pkg::CMD_TAKE: begin
              if (!full_r[d_idx]) begin
                res_status = osmt_pkg::ST_EMPTY;
              end else begin
                do_take = 1'b1;
              end
            end
            default: do_destroy = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= osmt_pkg::S_IDLE;
      in_use_r <= '0;
      full_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (do_claim) begin
        in_use_r[scan_r] <= 1'b1;
        full_r[scan_r]   <= 1'b0;
      end
      if (do_put) begin
        full_r[d_idx] <= 1'b1;
      end
      if (do_take) begin
        full_r[d_idx] <= 1'b0;
      end
      if (do_destroy) begin
        in_use_r[d_idx] <= 1'b0;
        full_r[d_idx]   <= 1'b0;
      end
    end
  end

  // word memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (do_put) begin
      slot_word[d_idx] <= value_r;
    end
    if (do_take) begin
      rd_data_r <= slot_word[d_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= osmt_pkg::cmd_t'(in_command);
      desc_r  <= in_descriptor;
      value_r <= in_value;
      scan_r  <= '0;
    end else if (state_r == osmt_pkg::S_SCAN && !scan_free && !scan_last) begin
      scan_r <= scan_r + 1'b1;
    end
    if (ld_result) begin
      status_r  <= res_status;
      granted_r <= res_granted;
      taken_r   <= '0;
    end else if (state_r == osmt_pkg::S_READ) begin
      taken_r <= rd_data_r;
    end
  end

  assign in_stall               = (state_r != osmt_pkg::S_IDLE);
  assign out_valid              = (state_r == osmt_pkg::S_DONE);
  assign out_status             = status_r;
  assign out_granted_descriptor = granted_r;
  assign out_taken_value        = taken_r;

endmodule

// ----- src/osmt_checker.sv -----
module osmt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [osmt_pkg::STATUS_W-1:0]      out_status,
  input logic [osmt_pkg::GRANT_W-1:0]       out_granted_descriptor,
  input logic signed [osmt_pkg::WORD_W-1:0] out_taken_value
);

  // one command in flight: an accepted beat closes the input side
  a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous command still open");

  a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while a result is pending");

  a_fail_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != osmt_pkg::ST_OK
      |-> out_granted_descriptor == '0 && out_taken_value == '0)
    else $error("failed command carries non-zero payload");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == osmt_pkg::ST_OK || out_status == osmt_pkg::ST_INVALID ||
      out_status == osmt_pkg::ST_NO_FREE || out_status == osmt_pkg::ST_FULL ||
      out_status == osmt_pkg::ST_EMPTY)
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_granted_descriptor) && $stable(out_taken_value))
    else $error("stalled result beat changed");

endmodule

bind one_slot_mailbox_table osmt_checker u_osmt_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_status             (out_status),
  .out_granted_descriptor (out_granted_descriptor),
  .out_taken_value        (out_taken_value)
);

// ----- tb/tb_one_slot_mailbox_table.sv -----
module tb_one_slot_mailbox_table;
  import osmt_pkg::*;

  localparam int ENTRIES        = ENTRY_COUNT_DEF;
  localparam int IDX_W          = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    status_t             status;
    logic [GRANT_W-1:0]  grant;
    logic [WORD_W-1:0]   taken;
  } mb_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command = '0;
  logic [DESC_W-1:0]        in_descriptor = '0;
  logic signed [WORD_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic [GRANT_W-1:0]       out_granted_descriptor;
  logic signed [WORD_W-1:0] out_taken_value;

  one_slot_mailbox_table #(.ENTRY_COUNT(ENTRIES)) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_command             (in_command),
    .in_descriptor          (in_descriptor),
    .in_value               (in_value),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_status             (out_status),
    .out_granted_descriptor (out_granted_descriptor),
    .out_taken_value        (out_taken_value)
  );

  always #10 clk = ~clk;

  // shadow copy of the mailbox table
  bit                mb_in_use [ENTRIES];
  bit                mb_full   [ENTRIES];
  logic [WORD_W-1:0] mb_word   [ENTRIES];

  mb_reply_t reply_q[$];

  int errors = 0;
  int items_sent = 0;
  int replies_checked = 0;
  int status_seen [5];
  int burst_left = 1;
  bit gaps_on = 1'b1;
  int hold_reqs = 0;

  function automatic mb_reply_t predict_mailbox(cmd_t cmd, logic [DESC_W-1:0] desc,
                                                logic [WORD_W-1:0] val);
    mb_reply_t r;
    int free_idx;
    logic [IDX_W-1:0] di;
    r.status = ST_OK;
    r.grant  = '0;
    r.taken  = '0;
    free_idx = -1;
    di       = desc[IDX_W-1:0];
    if (cmd == CMD_CREATE) begin
      for (int i = 0; i < ENTRIES; i++)
        if (!mb_in_use[i] && free_idx < 0) free_idx = i;
      if (free_idx < 0) begin
        r.status = ST_NO_FREE;
      end else begin
        mb_in_use[free_idx] = 1'b1;
        mb_full[free_idx]   = 1'b0;
        r.grant = free_idx[GRANT_W-1:0];
      end
    end else if (desc >= ENTRIES || !mb_in_use[di]) begin
      r.status = ST_INVALID;
    end else begin
      case (cmd)
        CMD_PUT: begin
          if (mb_full[di]) begin
            r.status = ST_FULL;
          end else begin
            mb_word[di] = val;
            mb_full[di] = 1'b1;
          end
        end
        CMD_TAKE: begin
          if (!mb_full[di]) begin
            r.status = ST_EMPTY;
          end else begin
            r.taken = mb_word[di];
            mb_full[di] = 1'b0;
          end
        end
        default: begin
          mb_in_use[di] = 1'b0;
          mb_full[di]   = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

  task automatic note_failure(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // Offers one command beat and holds it until accepted; the sender then
  // either carries straight on or drops valid for a random gap.
  task automatic send_item(cmd_t cmd, logic [DESC_W-1:0] desc,
                           logic signed [WORD_W-1:0] val);
    mb_reply_t r;
    int gap;
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_descriptor <= desc;
    in_value      <= val;
    do @(posedge clk); while (in_stall);
    r = predict_mailbox(cmd, desc, val);
    reply_q.push_back(r);
    status_seen[r.status]++;
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  function automatic cmd_t random_command(int create_pct, int destroy_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < create_pct) return CMD_CREATE;
    if (r >= 100 - destroy_pct) return CMD_DESTROY;
    return ($urandom_range(0, 1) == 0) ? CMD_PUT : CMD_TAKE;
  endfunction

  // mostly a live entry so put/take get past the in-use check
  function automatic logic [DESC_W-1:0] random_descriptor();
    int live[$];
    int c;
    c = $urandom_range(0, 99);
    for (int i = 0; i < ENTRIES; i++)
      if (mb_in_use[i]) live.push_back(i);
    if (c < 80 && live.size() != 0)
      return DESC_W'(live[$urandom_range(0, live.size() - 1)]);
    if (c < 92) return DESC_W'($urandom_range(0, ENTRIES - 1));
    return DESC_W'($urandom_range(0, 255));
  endfunction

  task automatic test_directed_basic();
    send_item(CMD_CREATE, 8'd255, -1);
    send_item(CMD_PUT, 8'd0, 32'sh7FFF_FFFF);
    send_item(CMD_PUT, 8'd0, 32'sh8000_0000);
    send_item(CMD_TAKE, 8'd0, '0);
    send_item(CMD_TAKE, 8'd0, '0);
    send_item(CMD_PUT, 8'd0, 32'sh8000_0000);
    send_item(CMD_TAKE, 8'd0, -1);
    send_item(CMD_PUT, 8'd0, -1);
    send_item(CMD_DESTROY, 8'd0, '0);
    send_item(CMD_TAKE, 8'd0, '0);
    send_item(CMD_CREATE, 8'd0, '0);
    send_item(CMD_TAKE, 8'd0, '0);
    send_item(CMD_PUT, 8'd0, '0);
    send_item(CMD_TAKE, 8'd0, '0);
    send_item(CMD_DESTROY, 8'd0, '0);
  endtask

  task automatic test_invalid_descriptors();
    send_item(CMD_PUT, 8'd0, 32'sh1234_5678);
    send_item(CMD_DESTROY, 8'd0, '0);
    send_item(CMD_PUT, DESC_W'(ENTRIES), -1);
    send_item(CMD_TAKE, 8'd255, '0);
    send_item(CMD_DESTROY, 8'd128, '0);
    send_item(CMD_TAKE, DESC_W'(ENTRIES - 1), '0);
  endtask

  task automatic test_table_full();
    repeat (ENTRIES + 1) send_item(CMD_CREATE, '0, '0);
    send_item(CMD_PUT, 8'd5, 32'shA5A5_5A5A);
    send_item(CMD_DESTROY, 8'd5, '0);
    send_item(CMD_DESTROY, 8'd9, '0);
    send_item(CMD_CREATE, 8'd9, '0);
    send_item(CMD_TAKE, 8'd5, '0);
    send_item(CMD_CREATE, 8'd5, '0);
    send_item(CMD_CREATE, 8'd0, '0);
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_reqs <= hold_reqs + 1;
    repeat (20) send_item(random_command(20, 15), random_descriptor(), $urandom);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traffic(int n_items);
    repeat (n_items) send_item(random_command(20, 15), random_descriptor(), $urandom);
  endtask

  // alternate filling and draining the table so both ends are reached often
  task automatic test_random_churn(int n_phases);
    for (int p = 0; p < n_phases; p++) begin
      if (p % 2 == 0)
        repeat (30) send_item(random_command(55, 5), random_descriptor(), $urandom);
      else
        repeat (30) send_item(random_command(10, 45), random_descriptor(), $urandom);
    end
  endtask

  // receiver stall pattern: modes change every so often, plus requested hold-offs
  int stall_mode = 0;
  int mode_left = 0;
  int sq_period = 2;
  int sq_phase = 0;
  int hold_left = 0;
  int holds_seen = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != holds_seen) begin
      holds_seen <= hold_reqs;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 200);
        sq_period  <= $urandom_range(2, 9);
        sq_phase   <= 0;
      end else begin
        mode_left <= mode_left - 1;
        sq_phase  <= (sq_phase + 1) % sq_period;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (sq_phase < sq_period / 2);
      endcase
    end
  end

  always @(posedge clk) begin
    mb_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      replies_checked++;
      if (reply_q.size() == 0) begin
        note_failure($sformatf("result beat with nothing expected: status %0d grant %0d value %h",
                               out_status, out_granted_descriptor, out_taken_value));
      end else begin
        want = reply_q.pop_front();
        if (out_status !== want.status || out_granted_descriptor !== want.grant ||
            out_taken_value !== want.taken)
          note_failure($sformatf(
            "mismatch: expected status %0d grant %0d value %h, got status %0d grant %0d value %h",
            want.status, want.grant, want.taken,
            out_status, out_granted_descriptor, out_taken_value));
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[one_slot_mailbox_table] ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basic();
    test_invalid_descriptors();
    test_table_full();
    test_backpressure();
    test_random_traffic(250);
    test_random_churn(5);

    in_valid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (reply_q.size() != 0)
      note_failure($sformatf("%0d expected results never arrived", reply_q.size()));

    $display("run: %0d commands, %0d result beats checked, %0d failures",
             items_sent, replies_checked, errors);
    $display("replies: ok %0d, invalid %0d, no-free %0d, full %0d, empty %0d; long hold-off done",
             status_seen[ST_OK], status_seen[ST_INVALID], status_seen[ST_NO_FREE],
             status_seen[ST_FULL], status_seen[ST_EMPTY]);
    if (errors == 0)
      $display("[one_slot_mailbox_table] OK");
    else
      $display("[one_slot_mailbox_table] ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/osmt_pkg.sv
src/one_slot_mailbox_table.sv
src/osmt_checker.sv
tb/tb_one_slot_mailbox_table.sv
